// ----- hw/rtl/jsri_pkg.sv -----
// jsri_pkg: item types, register indexes and fixed widths for the joint speed ramp integrator
// no dependencies; imported by jsri_mul and joint_speed_ramp_integrator
`timescale 1ns / 1ps
`default_nettype none

package jsri_pkg;

    // shift-add multiplier operand width
    localparam int MUL_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 3'd6;

    // register reset values
    localparam logic [15:0] RST_SPEED_SCALE   = 16'd256;
    localparam logic [30:0] RST_DEAD_BAND     = 31'd3277;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd50;

    typedef struct packed {
        logic               command_valid;
        logic signed [31:0] command_value;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] joint_position;
        logic signed [31:0] joint_velocity;
        logic signed [31:0] speed_steps;
        logic               stale_command;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/jsri_mul.sv -----
// jsri_mul: bit-serial shift-add unsigned multiplier, one multiplier bit per cycle
// depends on jsri_pkg for the operand width
`timescale 1ns / 1ps
`default_nettype none

module jsri_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [jsri_pkg::MUL_W-1:0]   i_a,
    input  wire logic [jsri_pkg::MUL_W-1:0]   i_b,
    output logic                              o_done,
    output logic [2*jsri_pkg::MUL_W-1:0]      o_prod
);
    import jsri_pkg::*;

    localparam int CNT_W = $clog2(MUL_W);

    logic [MUL_W-1:0]   r_a;
    logic [2*MUL_W-1:0] r_prod;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [MUL_W:0]     n_hi;

    // add the multiplicand into the upper half when the current multiplier bit is set
    always_comb begin
        if (r_prod[0]) begin
            n_hi = {1'b0, r_prod[2*MUL_W-1:MUL_W]} + {1'b0, r_a};
        end else begin
            n_hi = {1'b0, r_prod[2*MUL_W-1:MUL_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{MUL_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= {n_hi, r_prod[MUL_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- hw/rtl/joint_speed_ramp_integrator.sv -----
// joint_speed_ramp_integrator: per-joint speed command hold, deadzone, clamp, slew ramp and
// position / velocity integration; uses jsri_pkg and two jsri_mul serial multipliers
// one item at a time: a new item is accepted only when idle, and each item makes two
// 32-step passes of the bit-serial shift-add multipliers
// (command scaling first, then position and velocity products side by side)
// reset (synchronous, active low): registers to defaults, held command, age, rate and angle to 0
`timescale 1ns / 1ps
`default_nettype none

module joint_speed_ramp_integrator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input item channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire jsri_pkg::t_in_item                i_in_item,
    // result item channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output jsri_pkg::t_out_item                    o_out_item,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [jsri_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [jsri_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import jsri_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCALE_GO  = 3'd1;
    localparam logic [2:0] S_SCALE_WT  = 3'd2;
    localparam logic [2:0] S_SHAPE     = 3'd3;
    localparam logic [2:0] S_RAMP      = 3'd4;
    localparam logic [2:0] S_GAIN_GO   = 3'd5;
    localparam logic [2:0] S_GAIN_WT   = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    logic [2:0] r_state;

    // configuration registers
    logic [15:0] r_speed_scale;
    logic [30:0] r_dead_band;
    logic [30:0] r_speed_limit;
    logic [30:0] r_max_step;
    logic [15:0] r_timeout_ticks;
    logic [31:0] r_position_gain;
    logic [31:0] r_velocity_gain;

    // joint state
    logic signed [31:0] r_held;
    logic [15:0]        r_age;
    logic signed [31:0] r_rate;
    logic [47:0]        r_angle;
    logic               r_stale;

    // per-item working registers
    logic [39:0]        r_scaled_mag;
    logic signed [31:0] r_target;
    logic [31:0]        r_pos_mag;
    logic [31:0]        r_vel_mag;

    // result register, parts the output side from the sequencer
    logic               r_out_valid;
    t_out_item          r_out_item;

    // multiplier hookup
    logic               w_scale_start;
    logic               w_gain_start;
    logic               w_scale_done;
    logic               w_pos_done;
    logic               w_vel_done;
    logic [63:0]        w_scale_prod;
    logic [63:0]        w_pos_prod;
    logic [63:0]        w_vel_prod;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_out_free;

    // tick bookkeeping on accept
    logic [15:0]        n_age;
    logic               n_stale;
    logic signed [31:0] n_held;

    // combinational parts of each stage
    logic [31:0]        w_held_mag;
    logic [31:0]        w_rate_mag;
    logic [31:0]        n_target_mag;
    logic signed [31:0] n_target;
    logic signed [32:0] w_delta;
    logic [32:0]        w_delta_mag;
    logic signed [32:0] n_rate_wide;
    logic [47:0]        w_pos_inc;
    logic [31:0]        w_vel;
    logic [47:0]        n_angle;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // one item at a time: the sequencer takes a new tick only when idle
    assign o_in_stall = (r_state != S_IDLE);

    // age saturates, timeout clears the held command
    always_comb begin
        if (i_in_item.command_valid) begin
            n_age = '0;
        end else if (r_age != 16'hFFFF) begin
            n_age = r_age + 16'd1;
        end else begin
            n_age = r_age;
        end
        n_stale = (n_age > r_timeout_ticks);
        if (n_stale) begin
            n_held = '0;
        end else if (i_in_item.command_valid) begin
            n_held = i_in_item.command_value;
        end else begin
            n_held = r_held;
        end
    end

    // magnitudes; the most negative value maps to 2^31, which fits unsigned
    assign w_held_mag = r_held[31] ? (~r_held + 32'd1) : r_held;
    assign w_rate_mag = r_rate[31] ? (~r_rate + 32'd1) : r_rate;

    // deadzone then clamp on the scaled magnitude, sign of the held command reapplied
    always_comb begin
        if (r_scaled_mag < {9'd0, r_dead_band}) begin
            n_target_mag = '0;
        end else if (r_scaled_mag > {9'd0, r_speed_limit}) begin
            n_target_mag = {1'b0, r_speed_limit};
        end else begin
            n_target_mag = r_scaled_mag[31:0];
        end
        n_target = r_held[31] ? (~n_target_mag + 32'd1) : n_target_mag;
    end

    // slew limit toward the target
    always_comb begin
        w_delta     = {r_target[31], r_target} - {r_rate[31], r_rate};
        w_delta_mag = w_delta[32] ? (~w_delta + 33'd1) : w_delta;
        if (w_delta_mag > {2'b00, r_max_step}) begin
            if (w_delta[32]) begin
                n_rate_wide = {r_rate[31], r_rate} - {2'b00, r_max_step};
            end else begin
                n_rate_wide = {r_rate[31], r_rate} + {2'b00, r_max_step};
            end
        end else begin
            n_rate_wide = {r_target[31], r_target};
        end
    end

    // signed products from magnitudes, truncated toward zero
    assign w_pos_inc = r_rate[31] ? (~{16'd0, r_pos_mag} + 48'd1) : {16'd0, r_pos_mag};
    assign w_vel     = r_rate[31] ? (~r_vel_mag + 32'd1) : r_vel_mag;
    assign n_angle   = r_angle + w_pos_inc;

    assign w_scale_start = (r_state == S_SCALE_GO);
    assign w_gain_start  = (r_state == S_GAIN_GO);

    // scaling pass and position pass share one multiplier
    jsri_mul u_mul_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scale_start || w_gain_start),
        .i_a     (w_scale_start ? w_held_mag : w_rate_mag),
        .i_b     (w_scale_start ? {16'd0, r_speed_scale} : r_position_gain),
        .o_done  (w_pos_done),
        .o_prod  (w_pos_prod)
    );

    jsri_mul u_mul_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gain_start),
        .i_a     (w_rate_mag),
        .i_b     (r_velocity_gain),
        .o_done  (w_vel_done),
        .o_prod  (w_vel_prod)
    );

    assign w_scale_done = w_pos_done;
    assign w_scale_prod = w_pos_prod;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale   <= RST_SPEED_SCALE;
            r_dead_band     <= RST_DEAD_BAND;
            r_speed_limit   <= '0;
            r_max_step      <= '0;
            r_timeout_ticks <= RST_TIMEOUT_TICKS;
            r_position_gain <= '0;
            r_velocity_gain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SPEED_SCALE:   r_speed_scale   <= i_cfg_data[15:0];
                REG_DEAD_BAND:     r_dead_band     <= i_cfg_data[30:0];
                REG_SPEED_LIMIT:   r_speed_limit   <= i_cfg_data[30:0];
                REG_MAX_STEP:      r_max_step      <= i_cfg_data[30:0];
                REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[15:0];
                REG_POSITION_GAIN: r_position_gain <= i_cfg_data;
                REG_VELOCITY_GAIN: r_velocity_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and joint state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_age       <= '0;
            r_rate      <= '0;
            r_angle     <= '0;
            r_stale     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_held  <= n_held;
                        r_age   <= n_age;
                        r_stale <= n_stale;
                        r_state <= S_SCALE_GO;
                    end
                end
                S_SCALE_GO: begin
                    r_state <= S_SCALE_WT;
                end
                S_SCALE_WT: begin
                    if (w_scale_done) begin
                        r_state <= S_SHAPE;
                    end
                end
                S_SHAPE: begin
                    r_state <= S_RAMP;
                end
                S_RAMP: begin
                    r_rate  <= n_rate_wide[31:0];
                    r_state <= S_GAIN_GO;
                end
                S_GAIN_GO: begin
                    r_state <= S_GAIN_WT;
                end
                S_GAIN_WT: begin
                    if (w_pos_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait until the result register is free or being emptied
                    if (w_out_free) begin
                        r_angle     <= n_angle;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result valid: set on a finished item, cleared when the item leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCALE_WT && w_scale_done) begin
            r_scaled_mag <= w_scale_prod[47:8];
        end
        if (r_state == S_SHAPE) begin
            r_target <= n_target;
        end
        if (r_state == S_GAIN_WT && w_pos_done) begin
            r_pos_mag <= w_pos_prod[63:32];
            r_vel_mag <= w_vel_prod[63:32];
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_item.joint_position <= n_angle;
            r_out_item.joint_velocity <= w_vel;
            r_out_item.speed_steps    <= r_rate;
            r_out_item.stale_command  <= r_stale;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // an accepted tick always starts the scaling pass next
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SCALE_GO))
        else $error("accepted item did not start scaling");

    // the position and velocity multipliers run in lock step
    a_gain_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAIN_WT) |-> (w_pos_done == w_vel_done))
        else $error("gain multipliers out of step");

    // a timed-out tick always carries a cleared command into shaping
    a_stale_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHAPE && r_stale) |-> (r_held == 32'sd0))
        else $error("stale tick with nonzero held command");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result register overwritten while stalled");

    // the shared multiplier finishes only in the scaling or the gain wait state
    a_scale_done_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scale_done |-> (r_state == S_SCALE_WT || r_state == S_GAIN_WT))
        else $error("multiplier finished in unexpected state");

endmodule

`default_nettype wire
